// ----- hdl/sltu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SARSA(lambda) trace update package
// Types, constants and fixed-point helpers shared by the engine.
// ----------------------------------------------------------------------------
package sltu_pkg;

  localparam int unsigned StateW    = 8;
  localparam int unsigned ActionW   = 4;
  localparam int unsigned QAddrW    = StateW + ActionW;
  localparam int unsigned MaxTraces = 64;
  localparam int unsigned TrIdxW    = $clog2(MaxTraces);
  localparam int unsigned CountW    = TrIdxW + 1;
  localparam int unsigned RateW     = 17;
  localparam int unsigned QW        = 32;

  localparam logic [RateW-1:0]  OneQ16      = 17'd65536;
  localparam logic [RateW-1:0]  AlphaRst    = 17'd6554;
  localparam logic [RateW-1:0]  DiscountRst = 17'd58982;
  localparam logic [RateW-1:0]  LambdaRst   = 17'd58982;
  localparam logic [RateW-1:0]  TolRst      = 17'd66;
  localparam logic [RateW-1:0]  DecayRst    = 17'd53083;
  localparam logic [CountW-1:0] TraceFull   = CountW'(MaxTraces);

  typedef enum logic [1:0] {
    MODE_UPDATE = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_WRITE  = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_LEARNING_RATE = 2'd0,
    CFG_DISCOUNT      = 2'd1,
    CFG_LAMBDA        = 2'd2,
    CFG_TOLERANCE     = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    BK_INIT, BK_IDLE, BK_DISPATCH, BK_READ_OUT, BK_UPD_CUR, BK_DIFF,
    BK_TD_MUL, BK_TD_SAT, BK_WALK, BK_TR_EVAL, BK_TR_DEC, BK_DROP,
    BK_KEEP, BK_Q_MUL, BK_Q_ADD, BK_FRESH, BK_FINAL_RD, BK_FINAL
  } back_state_e;

  typedef struct packed {
    mode_e                mode;
    logic [StateW-1:0]    cur_state;
    logic [ActionW-1:0]   cur_action;
    logic [StateW-1:0]    next_state;
    logic [ActionW-1:0]   next_action;
    logic signed [QW-1:0] reward;
    logic signed [QW-1:0] write_value;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } bk_status_t;

  typedef struct packed {
    logic [RateW-1:0] alpha;
    logic [RateW-1:0] discount;
    logic [RateW-1:0] tolerance;
    logic [RateW-1:0] decay;
  } cfg_t;

  typedef struct packed {
    logic [StateW-1:0]  state_idx;
    logic [ActionW-1:0] action_idx;
    logic [RateW-1:0]   elig;
  } trace_t;

  function automatic logic [RateW-1:0] sat17_shr16(logic [33:0] p);
    if (p[33]) begin
      return 17'h1FFFF;
    end
    return p[32:16];
  endfunction

  function automatic logic [RateW-1:0] mul_q016(logic [RateW-1:0] a, logic [RateW-1:0] b);
    logic [33:0] p;
    p = 34'(a) * 34'(b);
    return sat17_shr16(p);
  endfunction

  function automatic logic signed [QW-1:0] sat32(logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end
    if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

// ----- hdl/sltu_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SARSA(lambda) input channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface sltu_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [7:0]         cur_state;
  logic [3:0]         cur_action;
  logic [7:0]         next_state;
  logic [3:0]         next_action;
  logic signed [31:0] reward;
  logic signed [31:0] write_value;

  modport source (
    output valid, mode, cur_state, cur_action, next_state, next_action, reward, write_value,
    input  ready
  );
  modport sink (
    input  valid, mode, cur_state, cur_action, next_state, next_action, reward, write_value,
    output ready
  );
endinterface

// ----- hdl/sltu_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SARSA(lambda) result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface sltu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] td_error;
  logic signed [31:0] q_value;
  logic [6:0]         trace_count;
  logic               trace_overflow;

  modport source (
    output valid, td_error, q_value, trace_count, trace_overflow,
    input  ready
  );
  modport sink (
    input  valid, td_error, q_value, trace_count, trace_overflow,
    output ready
  );
endinterface

// ----- hdl/sltu_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SARSA(lambda) front end
// Accepts command transfers, decodes the mode and queues them for the engine.
// ----------------------------------------------------------------------------
module sltu_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  sltu_in_if.sink                in_i,
  input  sltu_pkg::bk_status_t   status_i,
  output sltu_pkg::head_t        head_o
);
  import sltu_pkg::*;

  item_t      fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  item_t      in_item;

  assign in_i.ready = (cnt_q != 2'd2) && !status_i.busy;
  assign push       = in_i.valid && in_i.ready;

  always_comb begin
    in_item.mode        = mode_e'(in_i.mode);
    in_item.cur_state   = in_i.cur_state;
    in_item.cur_action  = in_i.cur_action;
    in_item.next_state  = in_i.next_state;
    in_item.next_action = in_i.next_action;
    in_item.reward      = in_i.reward;
    in_item.write_value = in_i.write_value;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (status_i.pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push && !status_i.pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && status_i.pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_item;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = fifo_q[rd_ptr_q];

endmodule

// ----- hdl/sltu_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SARSA(lambda) engine
// Sequencer over the Q table and trace memories; owns the result register.
// ----------------------------------------------------------------------------
module sltu_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sltu_pkg::cfg_t         cfg_i,
  input  sltu_pkg::head_t        head_i,
  output sltu_pkg::bk_status_t   status_o,
  sltu_out_if.source             out_o
);
  import sltu_pkg::*;

  localparam int unsigned QDepth = 2 ** QAddrW;

  back_state_e state_q, state_d;
  item_t       item_q, item_d;
  logic [QAddrW-1:0] clr_q, clr_d;
  logic [CountW-1:0] live_q, live_d;
  logic [CountW-1:0] i_q, i_d;
  logic fresh_q, fresh_d, ov_q, ov_d, walk_q, walk_d;
  logic signed [QW-1:0] td_q, td_d;
  logic [RateW-1:0]  el_q, el_d, el_dec;
  logic [QAddrW-1:0] qaddr_q, qaddr_d;
  logic signed [34:0] diff_q, diff_d;

  logic signed [49:0] disc_prod_q;
  logic signed [52:0] td_prod_q;
  logic [33:0]        dec_prod_q;
  logic signed [49:0] q_prod_q;

  logic [QW-1:0]        q_mem [QDepth];
  logic signed [QW-1:0] q_rdata_q;
  logic                 q_we;
  logic [QAddrW-1:0]    q_waddr, q_raddr;
  logic [QW-1:0]        q_wdata;

  trace_t             tr_mem [MaxTraces];
  trace_t             tr_rdata_q;
  logic               tr_we;
  logic [TrIdxW-1:0]  tr_waddr, tr_raddr;
  trace_t             tr_wdata;

  logic                 out_valid_q, out_load;
  logic signed [QW-1:0] out_td_q, out_td_d, out_q_q, out_q_d;
  logic [CountW-1:0]    out_cnt_q, out_cnt_d;
  logic                 out_ov_q, out_ov_d;

  logic [QAddrW-1:0] here, nxt;
  logic              match;
  logic [CountW-1:0] last;

  assign here   = {item_q.cur_state, item_q.cur_action};
  assign nxt    = {item_q.next_state, item_q.next_action};
  assign match  = (tr_rdata_q.state_idx == item_q.cur_state) &&
                  (tr_rdata_q.action_idx == item_q.cur_action);
  assign el_dec = sat17_shr16(dec_prod_q);
  assign last   = live_q - CountW'(1);

  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    clr_d     = clr_q;
    live_d    = live_q;
    i_d       = i_q;
    fresh_d   = fresh_q;
    ov_d      = ov_q;
    walk_d    = walk_q;
    td_d      = td_q;
    el_d      = el_q;
    qaddr_d   = qaddr_q;
    diff_d    = diff_q;
    q_we      = 1'b0;
    q_waddr   = qaddr_q;
    q_wdata   = '0;
    q_raddr   = qaddr_q;
    tr_we     = 1'b0;
    tr_waddr  = i_q[TrIdxW-1:0];
    tr_wdata  = tr_rdata_q;
    tr_raddr  = i_q[TrIdxW-1:0];
    out_load  = 1'b0;
    out_td_d  = '0;
    out_q_d   = '0;
    out_cnt_d = live_q;
    out_ov_d  = 1'b0;
    status_o.pop  = 1'b0;
    status_o.busy = (state_q == BK_INIT);

    case (state_q)
      BK_INIT: begin
        q_we    = 1'b1;
        q_waddr = clr_q;
        clr_d   = clr_q + QAddrW'(1);
        if (clr_q == '1) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (head_i.valid && !out_valid_q) begin
          status_o.pop = 1'b1;
          item_d       = head_i.item;
          state_d      = BK_DISPATCH;
        end
      end
      BK_DISPATCH: begin
        case (item_q.mode)
          MODE_UPDATE: begin
            q_raddr = nxt;
            state_d = BK_UPD_CUR;
          end
          MODE_CLEAR: begin
            live_d    = '0;
            out_load  = 1'b1;
            out_cnt_d = '0;
            state_d   = BK_IDLE;
          end
          MODE_WRITE: begin
            q_we     = 1'b1;
            q_waddr  = here;
            q_wdata  = item_q.write_value;
            out_load = 1'b1;
            out_q_d  = item_q.write_value;
            state_d  = BK_IDLE;
          end
          default: begin
            q_raddr = here;
            state_d = BK_READ_OUT;
          end
        endcase
      end
      BK_READ_OUT: begin
        out_load = 1'b1;
        out_q_d  = q_rdata_q;
        state_d  = BK_IDLE;
      end
      BK_UPD_CUR: begin
        q_raddr = here;
        state_d = BK_DIFF;
      end
      BK_DIFF: begin
        diff_d  = 35'(item_q.reward) + 35'(disc_prod_q >>> 16) - 35'(q_rdata_q);
        state_d = BK_TD_MUL;
      end
      BK_TD_MUL: begin
        state_d = BK_TD_SAT;
      end
      BK_TD_SAT: begin
        td_d    = sat32(64'(td_prod_q >>> 16));
        i_d     = '0;
        fresh_d = 1'b1;
        ov_d    = 1'b0;
        walk_d  = 1'b1;
        state_d = BK_WALK;
      end
      BK_WALK: begin
        if (i_q < live_q) begin
          state_d = BK_TR_EVAL;
        end else begin
          state_d = BK_FRESH;
        end
      end
      BK_TR_EVAL: begin
        if (match) begin
          el_d    = OneQ16;
          fresh_d = 1'b0;
          state_d = BK_KEEP;
        end else begin
          state_d = BK_TR_DEC;
        end
      end
      BK_TR_DEC: begin
        if (el_dec < cfg_i.tolerance) begin
          tr_raddr = last[TrIdxW-1:0];
          state_d  = BK_DROP;
        end else begin
          el_d    = el_dec;
          state_d = BK_KEEP;
        end
      end
      BK_DROP: begin
        // last entry moves into this slot, which is examined again
        tr_we   = 1'b1;
        live_d  = last;
        state_d = BK_WALK;
      end
      BK_KEEP: begin
        tr_we         = 1'b1;
        tr_wdata.elig = el_q;
        q_raddr       = {tr_rdata_q.state_idx, tr_rdata_q.action_idx};
        qaddr_d       = q_raddr;
        state_d       = BK_Q_MUL;
      end
      BK_Q_MUL: begin
        state_d = BK_Q_ADD;
      end
      BK_Q_ADD: begin
        q_we    = 1'b1;
        q_wdata = sat32(64'(q_rdata_q) + 64'(q_prod_q >>> 16));
        if (walk_q) begin
          i_d     = i_q + CountW'(1);
          state_d = BK_WALK;
        end else begin
          state_d = BK_FINAL_RD;
        end
      end
      BK_FRESH: begin
        qaddr_d = here;
        walk_d  = 1'b0;
        if (fresh_q) begin
          if (live_q != TraceFull) begin
            tr_we    = 1'b1;
            tr_waddr = live_q[TrIdxW-1:0];
            tr_wdata = '{state_idx: item_q.cur_state, action_idx: item_q.cur_action,
                         elig: OneQ16};
            live_d   = live_q + CountW'(1);
          end else begin
            ov_d = 1'b1;
          end
          el_d    = OneQ16;
          state_d = BK_Q_MUL;
        end else begin
          state_d = BK_FINAL_RD;
        end
      end
      BK_FINAL_RD: begin
        state_d = BK_FINAL;
      end
      BK_FINAL: begin
        out_load = 1'b1;
        out_td_d = td_q;
        out_q_d  = q_rdata_q;
        out_ov_d = ov_q;
        state_d  = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_INIT;
      clr_q       <= '0;
      live_q      <= '0;
      i_q         <= '0;
      fresh_q     <= 1'b0;
      ov_q        <= 1'b0;
      walk_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      live_q  <= live_d;
      i_q     <= i_d;
      fresh_q <= fresh_d;
      ov_q    <= ov_d;
      walk_q  <= walk_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    td_q        <= td_d;
    el_q        <= el_d;
    qaddr_q     <= qaddr_d;
    diff_q      <= diff_d;
    disc_prod_q <= $signed({1'b0, cfg_i.discount}) * q_rdata_q;
    td_prod_q   <= $signed({1'b0, cfg_i.alpha}) * diff_q;
    dec_prod_q  <= 34'(tr_rdata_q.elig) * 34'(cfg_i.decay);
    q_prod_q    <= td_q * $signed({1'b0, el_q});
    if (out_load) begin
      out_td_q  <= out_td_d;
      out_q_q   <= out_q_d;
      out_cnt_q <= out_cnt_d;
      out_ov_q  <= out_ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rdata_q <= q_mem[q_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tr_we) begin
      tr_mem[tr_waddr] <= tr_wdata;
    end
    tr_rdata_q <= tr_mem[tr_raddr];
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.td_error       = out_td_q;
  assign out_o.q_value        = out_q_q;
  assign out_o.trace_count    = out_cnt_q;
  assign out_o.trace_overflow = out_ov_q;

endmodule

// ----- hdl/sarsa_lambda_trace_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SARSA(lambda) trace update engine
// Tabular Q table with eligibility trace list, Q16.16 / Q1.16 fixed point.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake         | contents
//  in_i     | in  | valid/ready       | mode, s, a, s', a', reward, write value
//  out_o    | out | valid/ready       | td error, Q value, trace count, overflow
//  cfg      | in  | cfg_we_i          | register index, 17-bit data
//
//  A write or clear command finishes in the dispatch state; a read also passes
//  a read-out state. An update walks the trace list: a matching trace is set to
//  one, a decayed one is kept or dropped, and each kept trace and a new pair get
//  the per-trace multiply/add on their Q entry.
//  After reset the Q table is cleared one entry a cycle, with in_i.ready low.
//  Two commands queue ahead of the engine; a held result stops the engine only,
//  not the queue.
// ----------------------------------------------------------------------------
module sarsa_lambda_trace_update (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  sltu_in_if.sink                  in_i,
  sltu_out_if.source               out_o,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [sltu_pkg::RateW-1:0] cfg_wdata_i
);
  import sltu_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [RateW-1:0] lambda_q, lambda_d;
  head_t      head;
  bk_status_t status;

  always_comb begin
    cfg_d    = cfg_q;
    lambda_d = lambda_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LEARNING_RATE: cfg_d.alpha = cfg_wdata_i;
        CFG_DISCOUNT: begin
          cfg_d.discount = cfg_wdata_i;
          cfg_d.decay    = mul_q016(lambda_q, cfg_wdata_i);
        end
        CFG_LAMBDA: begin
          lambda_d    = cfg_wdata_i;
          cfg_d.decay = mul_q016(cfg_wdata_i, cfg_q.discount);
        end
        CFG_TOLERANCE: cfg_d.tolerance = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha     <= AlphaRst;
      cfg_q.discount  <= DiscountRst;
      cfg_q.tolerance <= TolRst;
      cfg_q.decay     <= DecayRst;
      lambda_q        <= LambdaRst;
    end else begin
      cfg_q    <= cfg_d;
      lambda_q <= lambda_d;
    end
  end

  sltu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .status_i (status),
    .head_o   (head)
  );

  sltu_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .head_i   (head),
    .status_o (status),
    .out_o    (out_o)
  );

endmodule

// ----- hdl/sltu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SARSA(lambda) port checker
// Checks on what the top level's ports show over time.
// ----------------------------------------------------------------------------
module sltu_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [31:0] td_error_i,
  input logic signed [31:0] q_value_i,
  input logic [6:0]         trace_count_i,
  input logic               trace_overflow_i
);

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (trace_count_i <= 7'd64))
    else $error("trace count beyond list size");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && trace_overflow_i) |-> (trace_count_i == 7'd64))
    else $error("overflow flagged with room in the list");

  a_init_blocks: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_ready_i)
    else $error("input taken during table clear");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      ($stable(td_error_i) && $stable(q_value_i) && $stable(trace_count_i) &&
       $stable(trace_overflow_i)))
    else $error("result changed while stalled");

endmodule

bind sarsa_lambda_trace_update sltu_checker u_sltu_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .td_error_i       (out_o.td_error),
  .q_value_i        (out_o.q_value),
  .trace_count_i    (out_o.trace_count),
  .trace_overflow_i (out_o.trace_overflow)
);

// ----- dv/sarsa_lambda_trace_update_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SARSA(lambda) trace update testbench
// Drives command transfers with random gaps, predicts each result with a
// behavioural model of the Q table and trace list, and checks every result
// transfer field by field. Several register settings are exercised.
// ----------------------------------------------------------------------------
module sarsa_lambda_trace_update_tb;
  import sltu_pkg::*;

  localparam int unsigned NumQ     = 4096;
  localparam int unsigned WdogMax  = 40000;

  typedef struct packed {
    logic signed [31:0] td_error;
    logic signed [31:0] q_value;
    logic [6:0]         trace_count;
    logic               trace_overflow;
  } result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [RateW-1:0] cfg_wdata_i;

  sltu_in_if  in_ch ();
  sltu_out_if out_ch ();

  sarsa_lambda_trace_update dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch.sink),
    .out_o       (out_ch.source),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // model state
  logic signed [31:0] q_mdl [NumQ];
  logic [7:0]  tr_s [MaxTraces];
  logic [3:0]  tr_a [MaxTraces];
  logic [16:0] tr_e [MaxTraces];
  int unsigned tr_live;
  logic [16:0] alpha_r, gamma_r, lambda_r, tol_r, decay_r;

  item_t   cmd_q [$];
  result_t result_q [$];
  int unsigned errors;
  int unsigned n_upd, n_ovf, n_res;
  bit hold_off;
  bit stim_done;
  int unsigned idle_cycles;

  function automatic logic [16:0] q016_mul(logic [16:0] x, logic [16:0] y);
    logic [33:0] p;
    p = 34'(x) * 34'(y);
    return (p[33:16] > 18'h1FFFF) ? 17'h1FFFF : p[32:16];
  endfunction

  function automatic longint floor16(longint x);
    return x >>> 16;
  endfunction

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic void q_accumulate(logic [QAddrW-1:0] addr, longint td, logic [16:0] el);
    longint inc;
    inc = floor16(td * longint'(el));
    q_mdl[addr] = clamp32(longint'(q_mdl[addr]) + inc);
  endfunction

  function automatic result_t predict_result(item_t it);
    result_t r;
    logic [QAddrW-1:0] here;
    int unsigned i, last;
    longint diff, td;
    logic [16:0] el;
    bit fresh;
    r = '0;
    here = {it.cur_state, it.cur_action};
    case (it.mode)
      MODE_UPDATE: begin
        diff = longint'(it.reward)
             + floor16(longint'(gamma_r) * longint'(q_mdl[{it.next_state, it.next_action}]))
             - longint'(q_mdl[here]);
        td = longint'(clamp32(floor16(longint'(alpha_r) * diff)));
        fresh = 1;
        i = 0;
        while (i < tr_live) begin
          if (tr_s[i] == it.cur_state && tr_a[i] == it.cur_action) begin
            el = OneQ16;
            fresh = 0;
          end else begin
            el = q016_mul(tr_e[i], decay_r);
            if (el < tol_r) begin
              last = tr_live - 1;
              tr_s[i] = tr_s[last];
              tr_a[i] = tr_a[last];
              tr_e[i] = tr_e[last];
              tr_live = last;
              continue;
            end
          end
          tr_e[i] = el;
          q_accumulate({tr_s[i], tr_a[i]}, td, el);
          i++;
        end
        if (fresh) begin
          if (tr_live < MaxTraces) begin
            tr_s[tr_live] = it.cur_state;
            tr_a[tr_live] = it.cur_action;
            tr_e[tr_live] = OneQ16;
            tr_live++;
          end else begin
            r.trace_overflow = 1'b1;
            n_ovf++;
          end
          q_accumulate(here, td, OneQ16);
        end
        r.td_error = td[31:0];
        r.q_value = q_mdl[here];
        n_upd++;
      end
      MODE_CLEAR: tr_live = 0;
      MODE_WRITE: begin
        q_mdl[here] = it.write_value;
        r.q_value = it.write_value;
      end
      default: r.q_value = q_mdl[here];
    endcase
    r.trace_count = 7'(tr_live);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp_v);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
    errors++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver
  int unsigned gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        result_q.push_back(predict_result(cmd_q.pop_front()));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_ch.valid && in_ch.ready) begin
          // cmd_q head already popped in this step via blocking call above
        end
        if (gap != 0) begin
          gap <= gap - 1;
          in_ch.valid <= 1'b0;
        end else if (cmd_q.size() > 0 && !(in_ch.valid && in_ch.ready && cmd_q.size() == 0)) begin
          in_ch.valid       <= 1'b1;
          in_ch.mode        <= cmd_q[0].mode;
          in_ch.cur_state   <= cmd_q[0].cur_state;
          in_ch.cur_action  <= cmd_q[0].cur_action;
          in_ch.next_state  <= cmd_q[0].next_state;
          in_ch.next_action <= cmd_q[0].next_action;
          in_ch.reward      <= cmd_q[0].reward;
          in_ch.write_value <= cmd_q[0].write_value;
          gap <= ($urandom_range(0, 3) == 0) ?
                 (($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 4)) : 0;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  result_t got, exp_r;
  int unsigned stall;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.td_error, out_ch.q_value, out_ch.trace_count, out_ch.trace_overflow};
        n_res++;
        if (result_q.size() == 0) begin
          report_mismatch("unexpected transfer", 0, 0);
        end else begin
          exp_r = result_q.pop_front();
          if (got.td_error !== exp_r.td_error)
            report_mismatch("td_error", got.td_error, exp_r.td_error);
          if (got.q_value !== exp_r.q_value)
            report_mismatch("q_value", got.q_value, exp_r.q_value);
          if (got.trace_count !== exp_r.trace_count)
            report_mismatch("trace_count", got.trace_count, exp_r.trace_count);
          if (got.trace_overflow !== exp_r.trace_overflow)
            report_mismatch("trace_overflow", got.trace_overflow, exp_r.trace_overflow);
        end
      end
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else if (stall != 0) begin
        stall <= stall - 1;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_off) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WdogMax) begin
      $display("watchdog expired");
      $display("Regression FAIL");
      $finish;
    end else if (!stim_done || result_q.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic item_t mk_item(mode_e m, int s, int a, int s1, int a1,
                                    logic [31:0] rw, logic [31:0] wv);
    item_t it;
    it.mode = m;
    it.cur_state = s[7:0];
    it.cur_action = a[3:0];
    it.next_state = s1[7:0];
    it.next_action = a1[3:0];
    it.reward = rw;
    it.write_value = wv;
    return it;
  endfunction

  function automatic logic [31:0] rnd_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? $urandom_range(0, 300000) : -$urandom_range(0, 300000);
      default: return $urandom();
    endcase
  endfunction

  task automatic wait_drained();
    wait (cmd_q.size() == 0 && !in_ch.valid);
    wait (result_q.size() == 0);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [16:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_LEARNING_RATE: alpha_r = val;
      CFG_DISCOUNT:      gamma_r = val;
      CFG_LAMBDA:        lambda_r = val;
      default:           tol_r = val;
    endcase
    decay_r = q016_mul(lambda_r, gamma_r);
  endtask

  // random phase: episodes over a bounded pool of states so traces build up
  task automatic random_phase(int unsigned count, int unsigned pool);
    int unsigned k;
    int s, a;
    for (k = 0; k < count; k++) begin
      s = $urandom_range(0, pool);
      a = $urandom_range(0, 15);
      case ($urandom_range(0, 19))
        0: cmd_q.push_back(mk_item(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom));
        1: cmd_q.push_back(mk_item(MODE_WRITE, s, a, $urandom, $urandom,
                                   $urandom, rnd_value()));
        2: cmd_q.push_back(mk_item(MODE_READ, $urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom));
        default: cmd_q.push_back(mk_item(MODE_UPDATE, s, a, $urandom_range(0, pool),
                                         $urandom_range(0, 15), rnd_value(), $urandom));
      endcase
    end
  endtask

  initial begin
    int unsigned k;
    errors = 0; n_upd = 0; n_ovf = 0; n_res = 0;
    hold_off = 0; stim_done = 0; idle_cycles = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = CFG_LEARNING_RATE; cfg_wdata_i = '0;
    in_ch.valid = 1'b0; in_ch.mode = MODE_READ;
    in_ch.cur_state = '0; in_ch.cur_action = '0; in_ch.next_state = '0;
    in_ch.next_action = '0; in_ch.reward = '0; in_ch.write_value = '0;
    out_ch.ready = 1'b0;
    for (k = 0; k < NumQ; k++) q_mdl[k] = '0;
    tr_live = 0;
    alpha_r = AlphaRst; gamma_r = DiscountRst; lambda_r = LambdaRst; tol_r = TolRst;
    decay_r = q016_mul(lambda_r, gamma_r);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset registers
    cmd_q.push_back(mk_item(MODE_READ, 255, 15, 0, 0, 0, 0));
    cmd_q.push_back(mk_item(MODE_WRITE, 255, 15, 0, 0, 0, 32'h7FFFFFFF));
    cmd_q.push_back(mk_item(MODE_WRITE, 0, 0, 0, 0, 0, 32'h80000000));
    cmd_q.push_back(mk_item(MODE_UPDATE, 1, 2, 255, 15, 32'h7FFFFFFF, 0));
    cmd_q.push_back(mk_item(MODE_UPDATE, 1, 2, 0, 0, 32'h80000000, 32'hFFFFFFFF));
    cmd_q.push_back(mk_item(MODE_UPDATE, 3, 4, 1, 2, 32'h00010000, 0));
    cmd_q.push_back(mk_item(MODE_UPDATE, 1, 2, 3, 4, 32'hFFFF0000, 0));
    cmd_q.push_back(mk_item(MODE_READ, 1, 2, 0, 0, 0, 0));
    cmd_q.push_back(mk_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk_item(MODE_UPDATE, 255, 15, 255, 15, 0, 0));
    wait_drained();

    // full trace list: tolerance 0, no decay, 70 distinct pairs
    write_reg(CFG_TOLERANCE, 17'd0);
    write_reg(CFG_LAMBDA, 17'd65536);
    write_reg(CFG_DISCOUNT, 17'd65536);
    write_reg(CFG_LEARNING_RATE, 17'd65536);
    cmd_q.push_back(mk_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0));
    for (k = 0; k < 70; k++)
      cmd_q.push_back(mk_item(MODE_UPDATE, k, k, k + 1, k, 32'h00000100, 0));
    // long receiver hold-off while commands keep coming
    hold_off = 1;
    repeat (3000) @(posedge clk_i);
    hold_off = 0;
    wait_drained();

    // extremes and odd settings
    write_reg(CFG_LEARNING_RATE, 17'd0);
    write_reg(CFG_LAMBDA, 17'd0);
    write_reg(CFG_DISCOUNT, 17'h1FFFF);
    write_reg(CFG_TOLERANCE, 17'h1FFFF);
    random_phase(40, 15);
    wait_drained();

    write_reg(CFG_LEARNING_RATE, 17'h1FFFF);
    write_reg(CFG_LAMBDA, 17'h1FFFF);
    write_reg(CFG_DISCOUNT, 17'd1);
    write_reg(CFG_TOLERANCE, 17'd66);
    random_phase(40, 7);
    wait_drained();

    write_reg(CFG_LEARNING_RATE, 17'd6554);
    write_reg(CFG_DISCOUNT, 17'd58982);
    write_reg(CFG_LAMBDA, 17'd58982);
    write_reg(CFG_TOLERANCE, 17'd66);
    random_phase(150, 10);
    wait_drained();

    write_reg(CFG_LEARNING_RATE, 17'd40000);
    write_reg(CFG_DISCOUNT, 17'd65000);
    write_reg(CFG_LAMBDA, 17'd64000);
    write_reg(CFG_TOLERANCE, 17'd3000);
    random_phase(140, 255);
    wait_drained();

    stim_done = 1;
    $display("covered %0d results, %0d updates, %0d overflowing appends, 6 register sets",
             n_res, n_upd, n_ovf);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
